### rtl/core/tofq_pkg.sv
`default_nettype none
package tofq_pkg;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_POPPED   = 3'd1;
    localparam logic [2:0] KIND_RELEASED = 3'd2;
    localparam logic [2:0] KIND_ACCEPTED = 3'd3;
    localparam logic [2:0] KIND_DROPPED  = 3'd4;

    localparam logic [1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [1:0] CFG_MIN_FILL  = 2'd1;
    localparam logic [1:0] CFG_SKIP_PAST = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  frame_handle;
        logic [31:0] frame_time;
        logic        time_valid;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_handle;
        logic [31:0] out_time;
        logic        last;
        logic        full_res;
        logic        has_frames;
        logic [4:0]  count;
    } t_res;

    typedef struct packed {
        logic [4:0] capacity;
        logic [4:0] min_fill;
        logic       skip_past;
    } t_cfg;

    typedef struct packed {
        logic [31:0] frame_time;
        logic [7:0]  frame_handle;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

### rtl/core/tofq_mem.sv
`default_nettype none
module tofq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire tofq_pkg::t_entry  i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output tofq_pkg::t_entry       o_rdata
);

    tofq_pkg::t_entry r_mem [DEPTH];
    tofq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/core/tofq_ctrl.sv
`default_nettype none
module tofq_ctrl #(
    parameter int DEPTH = 16,
    parameter int PW    = 4,
    parameter int CW    = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire tofq_pkg::t_req    i_req,
    input  wire tofq_pkg::t_cfg    i_cfg,
    output logic                   o_busy,
    output logic                   o_strobe,
    output tofq_pkg::t_res         o_res,
    output logic                   o_mem_we,
    output logic [PW-1:0]          o_mem_waddr,
    output tofq_pkg::t_entry       o_mem_wdata,
    output logic                   o_mem_re,
    output logic [PW-1:0]          o_mem_raddr,
    input  wire tofq_pkg::t_entry  i_mem_rdata
);

    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    tofq_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_left, n_left;
    logic [CW-1:0]    r_after, n_after;
    tofq_pkg::t_req   r_req, n_req;
    tofq_pkg::t_res   r_res, n_res;
    logic             r_strobe, n_strobe;

    logic [CMPW-1:0]  cap_x;
    logic [CW-1:0]    eff_cap;
    logic             push_full;
    logic             pop_ok;
    logic             rd_gt;
    logic             is_pop;
    tofq_pkg::t_entry new_entry;

    function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [CW-1:0] l);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(l);
        if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
        return s[PW-1:0];
    endfunction

    function automatic tofq_pkg::t_res mk_res(input logic [2:0] kind, input logic [7:0] h,
                                              input logic [31:0] t, input logic lst,
                                              input logic [CW-1:0] c, input logic [CW-1:0] cap);
        tofq_pkg::t_res r;
        logic [CMPW-1:0] cx;
        cx           = CMPW'(c);
        r.kind       = kind;
        r.out_handle = h;
        r.out_time   = t;
        r.last       = lst;
        r.full_res   = (c >= cap);
        r.has_frames = (c != '0);
        r.count      = cx[4:0];
        return r;
    endfunction

    always_comb begin
        cap_x = CMPW'(i_cfg.capacity);
        if (cap_x == '0) cap_x = CMPW'(1);
        if (cap_x > CMPW'(DEPTH)) cap_x = CMPW'(DEPTH);
        eff_cap = cap_x[CW-1:0];
    end

    assign push_full = (r_cnt >= eff_cap);
    assign pop_ok    = (CMPW'(r_cnt) >= CMPW'(i_cfg.min_fill)) && (r_cnt != '0);
    assign rd_gt     = (i_mem_rdata.frame_time > r_req.frame_time);
    assign is_pop    = (r_req.func == tofq_pkg::FUNC_POP);
    assign new_entry = '{frame_time: r_req.frame_time, frame_handle: r_req.frame_handle};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tofq_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_req.func)
                        tofq_pkg::FUNC_PUSH: begin
                            if (!push_full && r_cnt != '0) n_state = tofq_pkg::S_PUSH;
                        end
                        tofq_pkg::FUNC_POP: begin
                            if (pop_ok) begin
                                n_state = i_req.time_valid ? tofq_pkg::S_SCAN
                                                           : tofq_pkg::S_EMIT;
                            end
                        end
                        tofq_pkg::FUNC_FLUSH: begin
                            if (r_cnt != '0) n_state = tofq_pkg::S_EMIT;
                        end
                        default: n_state = tofq_pkg::S_IDLE;
                    endcase
                end
            end
            tofq_pkg::S_PUSH: begin
                if (!(r_pos != '0 && rd_gt)) n_state = tofq_pkg::S_IDLE;
            end
            tofq_pkg::S_SCAN: begin
                if (rd_gt) begin
                    n_state = (r_pos == '0) ? tofq_pkg::S_IDLE : tofq_pkg::S_EMIT;
                end else if (r_pos + CW'(1) == r_cnt) begin
                    n_state = tofq_pkg::S_EMIT;
                end
            end
            tofq_pkg::S_EMIT: begin
                if (r_left == CW'(1)) n_state = tofq_pkg::S_IDLE;
            end
            default: n_state = tofq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        logic [CW-1:0] n_le;
        logic [CW-1:0] nxt;
        n_le        = '0;
        nxt         = '0;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_left      = r_left;
        n_after     = r_after;
        n_req       = r_req;
        n_res       = r_res;
        n_strobe    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        unique case (r_state)
            tofq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_strobe = 1'b1;
                    n_res    = mk_res(tofq_pkg::KIND_NONE, 8'd0, 32'd0, 1'b1, r_cnt, eff_cap);
                    case (i_req.func)
                        tofq_pkg::FUNC_PUSH: begin
                            if (push_full) begin
                                n_res = mk_res(tofq_pkg::KIND_DROPPED, i_req.frame_handle,
                                               i_req.frame_time, 1'b1, r_cnt, eff_cap);
                            end else if (r_cnt == '0) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = phys(r_head, '0);
                                o_mem_wdata = '{frame_time: i_req.frame_time,
                                                frame_handle: i_req.frame_handle};
                                n_cnt       = CW'(1);
                                n_res       = mk_res(tofq_pkg::KIND_ACCEPTED,
                                                     i_req.frame_handle, i_req.frame_time,
                                                     1'b1, CW'(1), eff_cap);
                            end else begin
                                n_strobe    = 1'b0;
                                o_mem_re    = 1'b1;
                                o_mem_raddr = phys(r_head, r_cnt - CW'(1));
                                n_pos       = r_cnt;
                            end
                        end
                        tofq_pkg::FUNC_POP: begin
                            if (pop_ok) begin
                                n_strobe    = 1'b0;
                                o_mem_re    = 1'b1;
                                o_mem_raddr = phys(r_head, '0);
                                n_pos       = '0;
                                n_left      = i_cfg.skip_past ? r_cnt : CW'(1);
                                n_after     = r_cnt - (i_cfg.skip_past ? r_cnt : CW'(1));
                            end
                        end
                        tofq_pkg::FUNC_FLUSH: begin
                            if (r_cnt != '0) begin
                                n_strobe    = 1'b0;
                                o_mem_re    = 1'b1;
                                o_mem_raddr = phys(r_head, r_cnt - CW'(1));
                                n_pos       = r_cnt - CW'(1);
                                n_left      = r_cnt;
                                n_after     = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tofq_pkg::S_PUSH: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = phys(r_head, r_pos);
                if (r_pos != '0 && rd_gt) begin
                    o_mem_wdata = i_mem_rdata;
                    o_mem_re    = (r_pos >= CW'(2));
                    o_mem_raddr = phys(r_head, r_pos - CW'(2));
                    n_pos       = r_pos - CW'(1);
                end else begin
                    o_mem_wdata = new_entry;
                    n_cnt       = r_cnt + CW'(1);
                    n_strobe    = 1'b1;
                    n_res       = mk_res(tofq_pkg::KIND_ACCEPTED, r_req.frame_handle,
                                         r_req.frame_time, 1'b1, r_cnt + CW'(1), eff_cap);
                end
            end
            tofq_pkg::S_SCAN: begin
                if (rd_gt || r_pos + CW'(1) == r_cnt) begin
                    n_le = rd_gt ? r_pos : r_cnt;
                    if (n_le == '0) begin
                        n_strobe = 1'b1;
                        n_res    = mk_res(tofq_pkg::KIND_NONE, 8'd0, 32'd0, 1'b1,
                                          r_cnt, eff_cap);
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = phys(r_head, '0);
                        n_pos       = '0;
                        n_left      = i_cfg.skip_past ? n_le : CW'(1);
                        n_after     = r_cnt - (i_cfg.skip_past ? n_le : CW'(1));
                    end
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = phys(r_head, r_pos + CW'(1));
                    n_pos       = r_pos + CW'(1);
                end
            end
            tofq_pkg::S_EMIT: begin
                n_strobe = 1'b1;
                n_res    = mk_res((is_pop && r_left == CW'(1)) ? tofq_pkg::KIND_POPPED
                                                               : tofq_pkg::KIND_RELEASED,
                                  i_mem_rdata.frame_handle, i_mem_rdata.frame_time,
                                  (r_left == CW'(1)), r_after, eff_cap);
                if (r_left != CW'(1)) begin
                    nxt         = is_pop ? r_pos + CW'(1) : r_pos - CW'(1);
                    o_mem_re    = 1'b1;
                    o_mem_raddr = phys(r_head, nxt);
                    n_pos       = nxt;
                    n_left      = r_left - CW'(1);
                end else begin
                    n_cnt = r_after;
                    if (is_pop) n_head = phys(r_head, r_cnt - r_after);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tofq_pkg::S_IDLE;
            r_head   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_left  <= n_left;
        r_after <= n_after;
        r_req   <= n_req;
        r_res   <= n_res;
    end

    assign o_busy   = (r_state != tofq_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_res.last |=> r_strobe)
        else $error("result burst broken before last");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_res.last |-> r_state == tofq_pkg::S_IDLE)
        else $error("sequencer busy after last result");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == tofq_pkg::S_IDLE || r_state == tofq_pkg::S_PUSH))
        else $error("memory write outside push");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("frame count above depth");

    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tofq_pkg::S_SCAN) |=> $stable(r_cnt))
        else $error("count changed during scan");

endmodule
`default_nettype wire

### rtl/core/timestamp_ordered_frame_queue.sv
`default_nettype none
// Frame queue kept in ascending timestamp order in one DEPTH-entry ring
// memory. A request is taken when start is high and busy is low; results
// appear one per cycle on o_strobe and cannot be held off. A full push, an
// empty flush, a refused pop and func 3 answer on the next cycle without
// raising busy. A push into a non-empty queue walks back through the memory
// one entry a cycle past the k held frames later than the new one, then
// writes the new frame. A pop first scans (skipped when the target time is
// invalid), stepping the memory read port from the front, then emits its
// results. A flush of n frames releases all n, latest first.
module timestamp_ordered_frame_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tofq_pkg::t_req  i_req,
    output logic                 o_strobe,
    output tofq_pkg::t_res       o_res,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [4:0]      i_cfg_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tofq_pkg::t_cfg   r_cfg;
    logic             mem_we;
    logic [PW-1:0]    mem_waddr;
    tofq_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [PW-1:0]    mem_raddr;
    tofq_pkg::t_entry mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity  <= 5'd16;
            r_cfg.min_fill  <= 5'd1;
            r_cfg.skip_past <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tofq_pkg::CFG_CAPACITY:  r_cfg.capacity  <= i_cfg_data;
                tofq_pkg::CFG_MIN_FILL:  r_cfg.min_fill  <= i_cfg_data;
                tofq_pkg::CFG_SKIP_PAST: r_cfg.skip_past <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tofq_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_cfg       (r_cfg),
        .o_busy      (busy),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tofq_mem #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire
